// File: rtl/ccgp_pkg.sv
// Shared widths, register codes and types of the column cost greedy partitioner.
package ccgp_pkg;

  localparam int ZW       = 12;  // slice z
  localparam int CW       = 16;  // counters and worker index
  localparam int BXW      = 7;   // block_x, block_y
  localparam int BZW      = 12;  // block_z
  localparam int DCW      = 16;  // diff_cost, 8 fraction bits
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;
  localparam int RUN_SPAN = 4;

  localparam int HW       = 13;  // height + 2 rounded up to 4
  localparam int AREAW    = 15;  // (bx+2)*(by+2)
  localparam int BXYW     = 2 * BXW;
  localparam int BXYZW    = BXYW + BZW;
  localparam int DAW      = DCW + AREAW;
  localparam int PW       = DAW + HW;
  localparam int TW       = 47;  // signed cost thresholds
  localparam int SETTLE   = 6;   // cycles to refresh the cost constants
  localparam int SW       = 3;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [CFG_AW-1:0] {
    REG_BLOCK_X   = 2'd0,
    REG_BLOCK_Y   = 2'd1,
    REG_BLOCK_Z   = 2'd2,
    REG_DIFF_COST = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DAW-1:0]       diff_area;  // diff_cost * (bx+2)*(by+2)
    logic signed [TW-1:0] full_cost;  // full block cost, scaled by 256
    logic signed [TW-1:0] thr_run;    // full_cost - 2*256, threshold of a fresh run
  } cost_t;

  typedef struct packed {
    logic settled;
    logic reload;
  } settle_t;

  function automatic logic [HW-1:0] round_up4(input logic [HW-1:0] v);
    logic [HW-1:0] s;
    s = v + HW'(3);
    return {s[HW-1:2], 2'b00};
  endfunction

endpackage

// File: rtl/column_cost_greedy_partitioner_unit.sv
// An accepted request sits in the input register until the result register can take its result.
// Throughput: one request per cycle while the output is not stalled; the result register frees the input side.
// The cost test is one 31x13 multiply and a compare against a running threshold.
// Reset is asynchronous, active low; after reset and after every config write the
// input stalls while the multiplier pipeline refreshes the cost constants.
// Top level of the column cost greedy partitioner.
module column_cost_greedy_partitioner_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ccgp_pkg::CFG_AW-1:0]  cfg_index_i,
  input  logic [ccgp_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ccgp_pkg::ZW-1:0]      slice_z_i,
  input  logic                         column_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ccgp_pkg::CW-1:0]      dest_worker_o,
  output logic [ccgp_pkg::CW-1:0]      workers_used_o
);
  import ccgp_pkg::*;

  logic [BXW-1:0] block_x_q;
  logic [BXW-1:0] block_y_q;
  logic [BZW-1:0] block_z_q;
  logic [DCW-1:0] diff_cost_q;
  logic           cfg_we;
  cost_t          cost;
  settle_t        settle;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_x_q   <= BXW'(4);
      block_y_q   <= BXW'(4);
      block_z_q   <= BZW'(4);
      diff_cost_q <= DCW'(256);
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_BLOCK_X:   block_x_q   <= cfg_data_i[BXW-1:0];
        REG_BLOCK_Y:   block_y_q   <= cfg_data_i[BXW-1:0];
        REG_BLOCK_Z:   block_z_q   <= cfg_data_i[BZW-1:0];
        REG_DIFF_COST: diff_cost_q <= cfg_data_i[DCW-1:0];
        default: ;
      endcase
    end
  end

  ccgp_cost_table u_cost_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .block_x_i   (block_x_q),
    .block_y_i   (block_y_q),
    .block_z_i   (block_z_q),
    .diff_cost_i (diff_cost_q),
    .cost_o      (cost),
    .settle_o    (settle)
  );

  ccgp_run_core u_run_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cost_i         (cost),
    .settle_i       (settle),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .slice_z_i      (slice_z_i),
    .column_start_i (column_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_worker_o  (dest_worker_o),
    .workers_used_o (workers_used_o)
  );

endmodule

// File: rtl/ccgp_cost_table.sv
// Multiplier pipeline that derives the per-configuration cost constants.
module ccgp_cost_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ccgp_pkg::BXW-1:0]    block_x_i,
  input  logic [ccgp_pkg::BXW-1:0]    block_y_i,
  input  logic [ccgp_pkg::BZW-1:0]    block_z_i,
  input  logic [ccgp_pkg::DCW-1:0]    diff_cost_i,
  output ccgp_pkg::cost_t             cost_o,
  output ccgp_pkg::settle_t           settle_o
);
  import ccgp_pkg::*;

  logic [AREAW-1:0]     area_q;
  logic [BXYW-1:0]      bxy_q;
  logic [HW-1:0]        r4z_q;
  logic [DAW-1:0]       dca_q;
  logic [BXYZW-1:0]     bxyz_q;
  logic [PW-1:0]        pz_q;
  logic signed [TW-1:0] full_q;
  logic signed [TW-1:0] thr_run_q;
  logic [SW-1:0]        busy_q, busy_d;

  always_ff @(posedge clk_i) begin
    area_q    <= (AREAW'(block_x_i) + AREAW'(2)) * (AREAW'(block_y_i) + AREAW'(2));
    bxy_q     <= BXYW'(block_x_i) * BXYW'(block_y_i);
    r4z_q     <= round_up4(HW'(block_z_i) + HW'(2));
    dca_q     <= DAW'(diff_cost_i) * DAW'(area_q);
    bxyz_q    <= BXYZW'(bxy_q) * BXYZW'(block_z_i);
    pz_q      <= PW'(dca_q) * PW'(r4z_q);
    full_q    <= $signed(TW'(pz_q)) + $signed(TW'({bxyz_q, 8'b0}));
    thr_run_q <= full_q - TW'(512);
  end

  always_comb begin
    busy_d = busy_q;
    if (cfg_we_i) begin
      busy_d = SW'(SETTLE);
    end else if (busy_q != '0) begin
      busy_d = busy_q - SW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= SW'(SETTLE);
    end else begin
      busy_q <= busy_d;
    end
  end

  assign cost_o.diff_area  = dca_q;
  assign cost_o.full_cost  = full_q;
  assign cost_o.thr_run    = thr_run_q;
  assign settle_o.settled  = (busy_q == '0);
  assign settle_o.reload   = (busy_q == SW'(1)) && !cfg_we_i;

endmodule

// File: rtl/ccgp_run_core.sv
// Input register, run tracking with cost test, and result register.
module ccgp_run_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ccgp_pkg::cost_t          cost_i,
  input  ccgp_pkg::settle_t        settle_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ccgp_pkg::ZW-1:0]  slice_z_i,
  input  logic                     column_start_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ccgp_pkg::CW-1:0]  dest_worker_o,
  output logic [ccgp_pkg::CW-1:0]  workers_used_o
);
  import ccgp_pkg::*;

  logic                 in_vld_q, in_vld_d;
  logic [ZW-1:0]        z_q;
  logic                 col_q;
  logic                 res_vld_q, res_vld_d;
  logic [CW-1:0]        dest_q, dest_d;
  logic [CW-1:0]        used_q, used_d;

  logic [ZW-1:0]        zmin_q, zmin_d;
  logic [ZW:0]          zlimit_q, zlimit_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        wk_q, wk_d;
  logic                 seen_q, seen_d;
  logic signed [TW-1:0] thr_q, thr_d;  // full cost - next count * 256

  logic                 in_fire, advance, new_col, reach, split;
  logic [CW-1:0]        cnt_inc, wk_inc;
  logic [HW-1:0]        r4;
  logic [PW-1:0]        prod;
  logic [ZW:0]          z_span;

  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = settle_i.settled && (!in_vld_q || advance);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (advance) begin
      res_vld_d = 1'b1;
    end else if (out_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  assign new_col = col_q || !seen_q;
  assign cnt_inc = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + CW'(1);
  assign wk_inc  = (wk_q == CNT_MAX) ? wk_q : wk_q + CW'(1);
  assign r4      = round_up4(HW'(z_q) - HW'(zmin_q) + HW'(3));
  assign prod    = PW'(cost_i.diff_area) * PW'(r4);
  assign reach   = {1'b0, z_q} >= zlimit_q;
  assign split   = reach && ($signed(TW'(prod)) > thr_q);
  assign z_span  = (ZW+1)'(z_q) + (ZW+1)'(RUN_SPAN);

  always_comb begin
    zmin_d   = zmin_q;
    zlimit_d = zlimit_q;
    cnt_d    = cnt_q;
    wk_d     = wk_q;
    seen_d   = seen_q;
    thr_d    = thr_q;
    if (advance) begin
      if (new_col) begin
        if (seen_q) begin
          wk_d = wk_inc;
        end
        seen_d   = 1'b1;
        zmin_d   = z_q;
        zlimit_d = z_span;
        cnt_d    = CW'(1);
        thr_d    = cost_i.thr_run;
      end else begin
        cnt_d = cnt_inc;
        thr_d = (cnt_inc != CNT_MAX) ? thr_q - TW'(256) : thr_q;
        if (reach) begin
          zlimit_d = {1'b0, z_q} + (ZW+1)'(1);
        end
        if (split) begin
          zmin_d   = z_q;
          zlimit_d = z_span;
          wk_d     = wk_inc;
          cnt_d    = CW'(1);
          thr_d    = cost_i.thr_run;
        end
      end
    end else if (settle_i.reload) begin
      thr_d = cost_i.full_cost - $signed(TW'({cnt_inc, 8'b0}));
    end
  end

  assign dest_d = wk_d;
  assign used_d = (wk_d == CNT_MAX) ? CNT_MAX : wk_d + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
      zmin_q    <= '0;
      zlimit_q  <= '0;
      cnt_q     <= '0;
      wk_q      <= '0;
      seen_q    <= 1'b0;
      thr_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      res_vld_q <= res_vld_d;
      zmin_q    <= zmin_d;
      zlimit_q  <= zlimit_d;
      cnt_q     <= cnt_d;
      wk_q      <= wk_d;
      seen_q    <= seen_d;
      thr_q     <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      z_q   <= slice_z_i;
      col_q <= column_start_i;
    end
    if (advance) begin
      dest_q <= dest_d;
      used_q <= used_d;
    end
  end

  assign out_valid_o    = res_vld_q;
  assign dest_worker_o  = dest_q;
  assign workers_used_o = used_q;

  a_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> cnt_q != '0)
    else $error("run count is zero inside a run");

  a_limit_above_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> zlimit_q > {1'b0, zmin_q})
    else $error("run z limit not above run start");

  a_worker_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> wk_q >= $past(wk_q))
    else $error("worker index went backwards");

  a_used_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && dest_q != CNT_MAX) |-> used_q == dest_q + CW'(1))
    else $error("workers_used does not follow dest_worker");

endmodule

// File: tb/tb_column_cost_greedy_partitioner_unit.sv
// Self-checking testbench of the column cost greedy partitioner unit.
module tb_column_cost_greedy_partitioner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ccgp_pkg::*;

  typedef struct packed {
    logic [ZW-1:0] z;
    logic          col;
  } cell_t;

  typedef struct packed {
    logic [CW-1:0] dest;
    logic [CW-1:0] used;
  } alloc_t;

  logic              clk_i;
  logic              rst_ni         = 1'b0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  cfg_reg_e          cfg_index_i    = REG_BLOCK_X;
  logic [CFG_DW-1:0] cfg_data_i     = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [ZW-1:0]     slice_z_i      = '0;
  logic              column_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [CW-1:0]     dest_worker_o;
  logic [CW-1:0]     workers_used_o;

  column_cost_greedy_partitioner_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .slice_z_i      (slice_z_i),
    .column_start_i (column_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .dest_worker_o  (dest_worker_o),
    .workers_used_o (workers_used_o)
  );

  // partitioner shadow: configuration and run state
  logic [BXW-1:0] blk_x = 7'd4;
  logic [BXW-1:0] blk_y = 7'd4;
  logic [BZW-1:0] blk_z = 12'd4;
  logic [DCW-1:0] dcost = 16'd256;

  logic [ZW-1:0]  zmin_r   = '0;
  logic [ZW:0]    zlimit_r = '0;
  logic [CW-1:0]  count_r  = '0;
  logic [CW-1:0]  worker_r = '0;
  logic           seen_r   = 1'b0;

  cell_t  cell_q[$];
  alloc_t alloc_q[$];

  bit gaps_on   = 1'b1;
  bit stall_arm = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;
  int err_cnt = 0;
  int idle_cycles = 0;

  localparam int STALL_LEN = 300;
  localparam int WDOG_LIMIT = 3000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run cost in units of 1/256
  function automatic longint unsigned run_cost256(longint unsigned cnt,
                                                  longint unsigned height);
    longint unsigned area;
    longint unsigned span;
    area = (64'(blk_x) + 64'd2) * (64'(blk_y) + 64'd2);
    span = (height + 64'd5) & ~64'd3;
    return (cnt << 8) + 64'(dcost) * area * span;
  endfunction

  function automatic alloc_t place_cell(logic [ZW-1:0] z, logic col);
    alloc_t          a;
    longint unsigned full;
    longint unsigned cost;
    if (col || !seen_r) begin
      if (seen_r && worker_r != CNT_MAX) worker_r = worker_r + 16'd1;
      seen_r   = 1'b1;
      zmin_r   = z;
      zlimit_r = 13'(z) + 13'(RUN_SPAN);
      count_r  = 16'd1;
    end else begin
      if (count_r != CNT_MAX) count_r = count_r + 16'd1;
      if (13'(z) >= zlimit_r) begin
        full = run_cost256(64'(blk_x) * 64'(blk_y) * 64'(blk_z), 64'(blk_z));
        cost = run_cost256(64'(count_r), 64'(z) - 64'(zmin_r) + 64'd1);
        zlimit_r = 13'(z) + 13'd1;
        if (cost > full) begin
          zmin_r   = z;
          zlimit_r = 13'(z) + 13'(RUN_SPAN);
          if (worker_r != CNT_MAX) worker_r = worker_r + 16'd1;
          count_r  = 16'd1;
        end
      end
    end
    a.dest = worker_r;
    a.used = (worker_r != CNT_MAX) ? worker_r + 16'd1 : CNT_MAX;
    return a;
  endfunction

  function automatic void note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // request driver
  always @(posedge clk_i) begin : drv
    cell_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) alloc_q.push_back(place_cell(slice_z_i, column_start_i));
      if (!in_valid_i || in_ready_o) begin
        if (cell_q.size() != 0 && (!gaps_on || $urandom_range(99) >= 35)) begin
          nxt = cell_q.pop_front();
          in_valid_i     <= 1'b1;
          slice_z_i      <= nxt.z;
          column_start_i <= nxt.col;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk_i) begin : mon
    alloc_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (alloc_q.size() == 0) begin
          note_error($sformatf("unexpected result dest=%0d used=%0d",
                               dest_worker_o, workers_used_o));
        end else begin
          want = alloc_q.pop_front();
          if (dest_worker_o !== want.dest || workers_used_o !== want.used)
            note_error($sformatf("dest exp %0d got %0d, used exp %0d got %0d",
                                 want.dest, dest_worker_o, want.used, workers_used_o));
        end
      end
      if (stall_arm && !stall_done) begin
        stall_done  <= 1'b1;
        stall_left  <= STALL_LEN;
        out_ready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !gaps_on || $urandom_range(99) >= 35;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("column_cost_greedy_partitioner_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_cell(int z, bit col);
    cell_t c;
    c.z   = 12'(z);
    c.col = col;
    cell_q.push_back(c);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last register
  task automatic set_reg(cfg_reg_e idx, logic [CFG_DW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_BLOCK_X:   blk_x = val[BXW-1:0];
      REG_BLOCK_Y:   blk_y = val[BXW-1:0];
      REG_BLOCK_Z:   blk_z = val[BZW-1:0];
      REG_DIFF_COST: dcost = val[DCW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int bx, int by, int bz, int dc, bit junk);
    logic [CFG_DW-1:0] hi;
    hi = junk ? 16'($urandom) : '0;
    set_reg(REG_BLOCK_X, {hi[15:7], 7'(bx)});
    set_reg(REG_BLOCK_Y, {hi[15:7], 7'(by)});
    set_reg(REG_BLOCK_Z, {hi[15:12], 12'(bz)});
    set_reg(REG_DIFF_COST, 16'(dc));
    cfg_valid_i <= 1'b0;
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    @(negedge clk_i);
    while (cell_q.size() != 0 || alloc_q.size() != 0 || in_valid_i) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // mostly sorted columns with random content, some noise cells
  task automatic queue_cells(int n, int max_step);
    int made;
    int len;
    int z;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        add_cell($urandom_range(0, 4095), 1'($urandom));
        made++;
      end else begin
        len = $urandom_range(1, 30);
        z = ($urandom_range(3) == 0) ? $urandom_range(3900, 4095) : $urandom_range(0, 3000);
        for (int k = 0; k < len && made < n; k++) begin
          if (k > 0) begin
            if ($urandom_range(19) == 0) z -= $urandom_range(0, 8);
            else if ($urandom_range(14) == 0) z += $urandom_range(0, 1024);
            else z += $urandom_range(0, max_step);
            if (z > 4095) z = 4095;
            if (z < 0) z = 0;
          end
          add_cell(z, k == 0);
          made++;
        end
      end
    end
  endtask

  initial begin
    int bx;
    int by;
    int bz;
    int dc;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration; first cell carries no column mark
    add_cell(5, 0);   add_cell(5, 0);   add_cell(6, 0);   add_cell(9, 0);
    add_cell(7, 0);   add_cell(15, 0);  add_cell(20, 0);  add_cell(30, 0);
    add_cell(0, 1);   add_cell(0, 0);   add_cell(4095, 0);
    add_cell(4095, 1); add_cell(4095, 0); add_cell(4095, 0);
    add_cell(100, 1); add_cell(100, 1);
    add_cell(0, 1);   add_cell(1, 0);   add_cell(2, 0);   add_cell(3, 0);
    add_cell(4, 0);   add_cell(5, 0);   add_cell(6, 0);   add_cell(8, 0);
    add_cell(12, 0);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin bx = 1;   by = 1;   bz = 1;    dc = 0;     end
        1: begin bx = 127; by = 127; bz = 4095; dc = 65535; end
        2: begin bx = 0;   by = 0;   bz = 0;    dc = 0;     end
        3: begin bx = 64;  by = 64;  bz = 4095; dc = 65535; end
        default: begin
          bx = $urandom_range(1, 64);
          by = $urandom_range(1, 64);
          bz = ($urandom_range(9) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 32);
          dc = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1023);
        end
      endcase
      program_regs(bx, by, bz, dc, ph >= 4 && $urandom_range(1) == 1);
      gaps_on   <= (ph != 3);
      stall_arm <= (ph == 5);
      queue_cells(75, ((bz > 128) ? 128 : bz) / 2 + 1);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (alloc_q.size() != 0)
      note_error($sformatf("%0d results never arrived", alloc_q.size()));
    if (err_cnt == 0) begin
      $display("column_cost_greedy_partitioner_unit regression: pass");
    end else begin
      $display("column_cost_greedy_partitioner_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ccgp_pkg.sv
rtl/ccgp_cost_table.sv
rtl/ccgp_run_core.sv
rtl/column_cost_greedy_partitioner_unit.sv
tb/tb_column_cost_greedy_partitioner_unit.sv
